// ===== rtl/fatet_pkg.sv =====
// ----------------------------------------------------------------------------
// fatet_pkg
// Shared constants for the file allocation table entry engine: store size,
// bank geometry, entry marks, opcodes and stream field widths.
// ----------------------------------------------------------------------------
package fatet_pkg;

    // byte store, split into an even-address bank and an odd-address bank
    localparam int TABLE_BYTES = 8192;
    localparam int BANK_DEPTH  = (TABLE_BYTES + 1) / 2;
    localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // byte address of an entry: 3*cluster needs 18 bits before the shift
    localparam int CLUS_W = 16;
    localparam int SUM_W  = CLUS_W + 2;
    localparam int ADDR_W = SUM_W;

    localparam int ENTRY_W = 16;

    // entry marks
    localparam logic [11:0] MASK12   = 12'hfff;
    localparam logic [11:0] END12    = 12'hfff;
    localparam logic [11:0] BAD12    = 12'hff7;
    localparam logic [11:0] UNUSED12 = 12'hffe;
    localparam logic [15:0] END16    = 16'hffff;
    localparam logic [15:0] BAD16    = 16'hfff7;
    localparam logic [15:0] UNUSED16 = 16'hfffe;

    localparam logic [7:0] HI_NIB = 8'hf0;
    localparam logic [7:0] LO_NIB = 8'h0f;

    // opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 5;

    // result flags, highest bit first in m_tuser
    typedef struct packed {
        logic address_error;
        logic is_unused_mark;
        logic is_bad_mark;
        logic is_end_mark;
        logic is_free;
    } result_flags_t;

endpackage

// ===== rtl/fat_entry_table_engine.sv =====
// ----------------------------------------------------------------------------
// fat_entry_table_engine
// Reads and writes 12-bit packed or 16-bit entries of a file allocation table
// held in two byte-wide synchronous banks, and flags the special entry marks.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata {entry_in, cluster}, s_tuser opcode
//  m_*       out        m_tvalid/m_tready  m_tdata entry_out, m_tuser flags
//  cfg_*     in         cfg_we             cfg_wdata wide_entries
//
//  every item is read, then merged: at the accept both bytes of the entry are read
//  from the even and odd banks; in the busy state the nibbles are merged, written
//  back and the result loaded. after reset both banks are cleared together, all
//  BANK_DEPTH (4096) rows, with s_tready low; configuration writes are taken
//  during the sweep. a waiting result does not block the next accept; a result
//  stalled on m_tready holds the item in the busy state until the output slot frees.
//
module fat_entry_table_engine
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fatet_pkg::S_TDATA_W-1:0]  s_tdata,   // cluster[15:0], entry_in[31:16]
    input  logic [fatet_pkg::S_TUSER_W-1:0]  s_tuser,   // opcode[0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fatet_pkg::M_TDATA_W-1:0]  m_tdata,   // entry_out[15:0]
    output logic [fatet_pkg::M_TUSER_W-1:0]  m_tuser,   // is_free[0], is_end_mark[1],
                                                        // is_bad_mark[2], is_unused_mark[3],
                                                        // address_error[4]
    input  logic                             cfg_we,
    input  logic                             cfg_wdata  // wide_entries
);

    import fatet_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [BANK_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic               wide_reg;

    // held item
    logic               op_reg;
    logic               odd_reg;
    logic               err_reg;
    logic               alo_reg;
    logic [BANK_AW-1:0] even_idx_reg;
    logic [BANK_AW-1:0] odd_idx_reg;
    logic [15:0]        val_reg;

    // output slot
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        out_data_reg;
    result_flags_t      out_flags_reg;

    // banks
    logic [7:0]         even_mem [BANK_DEPTH];
    logic [7:0]         odd_mem  [BANK_DEPTH];
    logic [7:0]         even_rdata_reg;
    logic [7:0]         odd_rdata_reg;

    logic               s_accept;
    logic               out_free;
    logic               finish;

    logic [CLUS_W-1:0]  in_clus;
    logic [SUM_W-1:0]   in_sum;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  in_addr_p1;
    logic               in_err;
    logic               rd_en;

    logic [7:0]         byte0, byte1;
    logic [7:0]         new0, new1;
    logic [15:0]        rd_val;
    result_flags_t      rd_flags;

    logic               even_we, odd_we;
    logic [BANK_AW-1:0] even_widx, odd_widx;
    logic [7:0]         even_wdata, odd_wdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign finish   = (state_reg == ST_BUSY) && out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flags_reg;

    // byte address of the entry
    always_comb
    begin
        in_clus = s_tdata[CLUS_W-1:0];
        in_sum  = {2'b00, in_clus} + {1'b0, in_clus, 1'b0};
        if (wide_reg)
            in_addr = {1'b0, in_clus, 1'b0};
        else
            in_addr = {1'b0, in_sum[SUM_W-1:1]};
        in_addr_p1 = in_addr + ADDR_W'(1);
        in_err     = (in_addr_p1 >= ADDR_W'(TABLE_BYTES));
        rd_en      = s_accept && !in_err;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + BANK_AW'(1);
                if (clr_cnt_reg == BANK_AW'(BANK_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_accept)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            wide_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                wide_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // item capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg       <= s_tuser[0];
            odd_reg      <= in_clus[0];
            err_reg      <= in_err;
            alo_reg      <= in_addr[0];
            even_idx_reg <= in_addr_p1[BANK_AW:1];
            odd_idx_reg  <= in_addr[BANK_AW:1];
            val_reg      <= s_tdata[S_TDATA_W-1:CLUS_W];
        end
    end

    // entry bytes in address order
    always_comb
    begin
        if (alo_reg)
        begin
            byte0 = odd_rdata_reg;
            byte1 = even_rdata_reg;
        end
        else
        begin
            byte0 = even_rdata_reg;
            byte1 = odd_rdata_reg;
        end
    end

    // read decode and write merge
    always_comb
    begin
        rd_val   = '0;
        rd_flags = '0;
        new0     = byte0;
        new1     = byte1;
        if (wide_reg)
        begin
            rd_val               = {byte1, byte0};
            rd_flags.is_end_mark    = (rd_val == END16);
            rd_flags.is_bad_mark    = (rd_val == BAD16);
            rd_flags.is_unused_mark = (rd_val == UNUSED16);
            new0 = val_reg[7:0];
            new1 = val_reg[15:8];
        end
        else
        begin
            if (odd_reg)
            begin
                rd_val = {4'h0, byte1, byte0[7:4]};
                // keep the even neighbor's low nibble
                new0   = (byte0 & LO_NIB) | {val_reg[3:0], 4'h0};
                new1   = val_reg[11:4];
            end
            else
            begin
                rd_val = {4'h0, byte1[3:0], byte0};
                new0   = val_reg[7:0];
                // keep the odd neighbor's high nibble
                new1   = (byte1 & HI_NIB) | {4'h0, val_reg[11:8]};
            end
            rd_flags.is_end_mark    = (rd_val[11:0] == END12);
            rd_flags.is_bad_mark    = (rd_val[11:0] == BAD12);
            rd_flags.is_unused_mark = (rd_val[11:0] == UNUSED12);
        end
        rd_flags.is_free = (rd_val == 16'h0000);
    end

    // output slot payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (err_reg)
            begin
                out_data_reg  <= '0;
                out_flags_reg <= '{address_error: 1'b1, default: 1'b0};
            end
            else if (op_reg == OP_WRITE)
            begin
                out_data_reg  <= '0;
                out_flags_reg <= '0;
            end
            else
            begin
                out_data_reg  <= rd_val;
                out_flags_reg <= rd_flags;
            end
        end
    end

    // bank write port: clearing sweep or write-back
    always_comb
    begin
        even_we    = 1'b0;
        odd_we     = 1'b0;
        even_widx  = even_idx_reg;
        odd_widx   = odd_idx_reg;
        even_wdata = alo_reg ? new1 : new0;
        odd_wdata  = alo_reg ? new0 : new1;
        if (state_reg == ST_CLEAR)
        begin
            even_we    = 1'b1;
            odd_we     = 1'b1;
            even_widx  = clr_cnt_reg;
            odd_widx   = clr_cnt_reg;
            even_wdata = '0;
            odd_wdata  = '0;
        end
        else if (finish && !err_reg && (op_reg == OP_WRITE))
        begin
            even_we = 1'b1;
            odd_we  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (even_we)
            even_mem[even_widx] <= even_wdata;
        if (rd_en)
            even_rdata_reg <= even_mem[in_addr_p1[BANK_AW:1]];
    end

    always_ff @(posedge clk)
    begin
        if (odd_we)
            odd_mem[odd_widx] <= odd_wdata;
        if (rd_en)
            odd_rdata_reg <= odd_mem[in_addr[BANK_AW:1]];
    end

    // an accepted item never overlaps the next one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("item accepted while previous item still in progress");

    // banks are only written by the sweep or by finishing a write item
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!even_we && !odd_we))
        else $error("bank written while idle");

    // error results carry no entry and no marks
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[4]) |-> ((m_tdata == '0) && (m_tuser[3:0] == '0)))
        else $error("address error result carries data");

    // a free entry reads as zero
    a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("free flag with nonzero entry");

    // results only come out of the merge cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_BUSY))
        else $error("result loaded outside merge cycle");

endmodule

// ===== sim/tb_fat_entry_table_engine.sv =====
// ----------------------------------------------------------------------------
// tb_fat_entry_table_engine
// Self-checking bench for the file allocation table entry engine. A driver
// feeds read and write items from a queue, and a monitor predicts every
// result from a shadow copy of the byte store. It covers the 12-bit packed
// and 16-bit entry formats, the entry marks and the store boundary, under
// several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_fat_entry_table_engine;

    import fatet_pkg::*;

    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 115;
    localparam int DRAIN_CYCLES  = 8;
    localparam int WATCHDOG_MAX  = 20000;

    localparam int SEND_IDLE_PCT  [NUM_PHASES] = '{0, 0, 88, 0, 33, 88, 0, 33};
    localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 0, 88, 33, 0, 88, 33};

    localparam logic [15:0] MARK_VALUES [7] = '{
        16'h0000, {4'h0, END12}, {4'h0, BAD12}, {4'h0, UNUSED12},
        END16, BAD16, UNUSED16
    };

    typedef struct packed {
        logic        opcode;
        logic [15:0] cluster;
        logic [15:0] entry_in;
    } fat_cmd_t;

    typedef struct packed {
        logic [15:0]   entry;
        result_flags_t flags;
    } fat_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_wdata = 1'b0;

    fat_cmd_t    cmd_queue [$];
    fat_result_t expected_entries [$];
    logic [7:0]  fat_bytes [0:TABLE_BYTES-1];
    logic        wide_mode = 1'b0;
    bit          in_taken  = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    fat_entry_table_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // cluster[15:0], entry_in[31:16]
        .s_tuser   (s_tuser),    // opcode[0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // entry_out[15:0]
        .m_tuser   (m_tuser),    // is_free[0], is_end_mark[1], is_bad_mark[2],
                                 // is_unused_mark[3], address_error[4]
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)   // wide_entries
    );

    always #6 clk = ~clk;

    // last cluster whose two entry bytes still fit in the store
    function automatic int unsigned last_cluster(input logic wide);
        return wide ? (TABLE_BYTES / 2 - 1) : ((2 * (TABLE_BYTES - 2) + 1) / 3);
    endfunction

    function automatic fat_result_t predict_entry(input fat_cmd_t c);
        fat_result_t r;
        int unsigned addr;
        logic [11:0] v12;
        logic [15:0] rd;
        r = '0;
        addr = wide_mode ? 2 * c.cluster : (3 * c.cluster) / 2;
        if (addr + 1 >= TABLE_BYTES)
        begin
            r.flags.address_error = 1'b1;
            return r;
        end
        v12 = c.entry_in[11:0];
        if (c.opcode == OP_WRITE)
        begin
            if (wide_mode)
            begin
                fat_bytes[addr]     = c.entry_in[7:0];
                fat_bytes[addr + 1] = c.entry_in[15:8];
            end
            else if (c.cluster[0])
            begin
                // odd entry: keep the even neighbor's low nibble
                fat_bytes[addr]     = (fat_bytes[addr] & LO_NIB) | {v12[3:0], 4'h0};
                fat_bytes[addr + 1] = v12[11:4];
            end
            else
            begin
                fat_bytes[addr]     = v12[7:0];
                fat_bytes[addr + 1] = (fat_bytes[addr + 1] & HI_NIB) | {4'h0, v12[11:8]};
            end
            return r;
        end
        if (wide_mode)
        begin
            rd = {fat_bytes[addr + 1], fat_bytes[addr]};
            r.flags.is_end_mark    = (rd == END16);
            r.flags.is_bad_mark    = (rd == BAD16);
            r.flags.is_unused_mark = (rd == UNUSED16);
        end
        else
        begin
            if (c.cluster[0])
                rd = {4'h0, fat_bytes[addr + 1], fat_bytes[addr][7:4]};
            else
                rd = {4'h0, fat_bytes[addr + 1][3:0], fat_bytes[addr]};
            r.flags.is_end_mark    = (rd[11:0] == END12);
            r.flags.is_bad_mark    = (rd[11:0] == BAD12);
            r.flags.is_unused_mark = (rd[11:0] == UNUSED12);
        end
        r.entry = rd;
        r.flags.is_free = (rd == 16'h0000);
        return r;
    endfunction

    function automatic fat_cmd_t random_cmd(input logic wide);
        fat_cmd_t c;
        int unsigned pick;
        int unsigned top;
        top = last_cluster(wide);
        c.opcode = $urandom_range(1) ? OP_WRITE : OP_READ;
        pick = $urandom_range(99);
        // mostly a small window so reads land on earlier writes
        if (pick < 55)
            c.cluster = 16'($urandom_range(47));
        else if (pick < 75)
            c.cluster = 16'($urandom_range(top));
        else if (pick < 87)
            c.cluster = 16'(top - 3 + $urandom_range(6));
        else
            c.cluster = 16'($urandom);
        if ($urandom_range(1))
            c.entry_in = 16'($urandom);
        else
        begin
            c.entry_in = MARK_VALUES[$urandom_range(6)];
            if (!wide && $urandom_range(1))
                c.entry_in[15:12] = 4'($urandom_range(15));
        end
        return c;
    endfunction

    task automatic queue_item(input logic op, input logic [15:0] clus,
                              input logic [15:0] val);
        cmd_queue.push_back('{opcode: op, cluster: clus, entry_in: val});
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_flag(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_tvalid || expected_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic wide);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= wide;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // driver: next item once the current one is taken
    always @(negedge clk)
    begin : driver
        fat_cmd_t c;
        if (!s_tvalid || in_taken)
        begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                c = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {c.entry_in, c.cluster};
                s_tuser  <= c.opcode;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        fat_cmd_t      c;
        fat_result_t   want;
        result_flags_t got_flags;
        in_taken = rst_n && s_tvalid && s_tready;
        if (rst_n && cfg_we)
            wide_mode = cfg_wdata;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_flags = m_tuser;
            if (expected_entries.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h %b",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = expected_entries.pop_front();
                check_field("entry_out", want.entry, m_tdata);
                check_flag("is_free", want.flags.is_free, got_flags.is_free);
                check_flag("is_end_mark", want.flags.is_end_mark, got_flags.is_end_mark);
                check_flag("is_bad_mark", want.flags.is_bad_mark, got_flags.is_bad_mark);
                check_flag("is_unused_mark", want.flags.is_unused_mark,
                           got_flags.is_unused_mark);
                check_flag("address_error", want.flags.address_error,
                           got_flags.address_error);
            end
        end
        if (in_taken)
        begin
            c.opcode   = s_tuser[0];
            c.cluster  = s_tdata[15:0];
            c.entry_in = s_tdata[31:16];
            expected_entries.push_back(predict_entry(c));
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned top12;
        int unsigned top16;
        for (int i = 0; i < TABLE_BYTES; i++)
            fat_bytes[i] = 8'h00;
        top12 = last_cluster(1'b0);
        top16 = last_cluster(1'b1);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_mode(p[0]);
            @(posedge clk);
            send_idle_pct  = SEND_IDLE_PCT[p];
            recv_stall_pct = RECV_STALL_PCT[p];
            if (p == 0)
            begin
                // packed entries: shared nibbles, marks, masking, boundary
                queue_item(OP_READ,  16'd0, 16'h0000);
                queue_item(OP_WRITE, 16'd0, 16'h0abc);
                queue_item(OP_WRITE, 16'd1, 16'h0123);
                queue_item(OP_READ,  16'd0, 16'hffff);
                queue_item(OP_READ,  16'd1, 16'h0000);
                queue_item(OP_WRITE, 16'd2, {4'h0, END12});
                queue_item(OP_WRITE, 16'd3, {4'h0, BAD12});
                queue_item(OP_READ,  16'd2, 16'h0000);
                queue_item(OP_READ,  16'd3, 16'h0000);
                queue_item(OP_WRITE, 16'd4, UNUSED16);
                queue_item(OP_READ,  16'd4, 16'h0000);
                queue_item(OP_WRITE, top12[15:0], 16'h05a5);
                queue_item(OP_READ,  top12[15:0], 16'h0000);
                queue_item(OP_READ,  top12[15:0] + 16'd1, 16'h0000);
                queue_item(OP_WRITE, 16'hffff, 16'hffff);
            end
            else if (p == 1)
            begin
                // wide entries: marks and the last entry of the store
                queue_item(OP_WRITE, 16'd0, END16);
                queue_item(OP_READ,  16'd0, 16'h0000);
                queue_item(OP_WRITE, 16'd1, BAD16);
                queue_item(OP_READ,  16'd1, 16'h0000);
                queue_item(OP_WRITE, 16'd2, UNUSED16);
                queue_item(OP_READ,  16'd2, 16'h0000);
                queue_item(OP_WRITE, top16[15:0], 16'h8001);
                queue_item(OP_READ,  top16[15:0], 16'h0000);
                queue_item(OP_READ,  top16[15:0] + 16'd1, 16'h0000);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                cmd_queue.push_back(random_cmd(p[0]));
        end

        wait_drained();
        if (errors == 0 && expected_entries.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
